// ===== src/text_line_filter_macros.svh =====
// ----------------------------------------------------------------------------
// text_line_filter assertion macros
// Concurrent assertion shorthands; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_FILTER_MACROS_SVH
`define TEXT_LINE_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define TLF_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// condition must never be seen outside reset
`define TLF_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);
`else
`define TLF_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define TLF_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif

`endif

// ===== src/tlf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types and constants of the text line filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tlf_pkg;

  localparam int NUMBER_DIGITS_DEFAULT = 6;
  localparam int QUEUE_DEPTH           = 4;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

  // characters
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NL      = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_DOLLAR  = 8'd36;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_I       = 8'd73;
  localparam logic [7:0] CHAR_CARET   = 8'd94;
  localparam logic [7:0] CHAR_DEL     = 8'd127;
  localparam logic [7:0] CTRL_LIMIT   = 8'd32;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  localparam logic [3:0] BCD_NINE = 4'd9;
  localparam logic [3:0] BCD_ZERO = 4'd0;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // per-request descriptor handed from front to back (line number travels beside it)
  typedef struct packed {
    logic       num_en;
    logic       lead_en;
    logic [7:0] lead_byte;
    logic [7:0] last_byte;
  } desc_t;

endpackage

`default_nettype wire

// ===== src/tlf_front.sv =====
// ----------------------------------------------------------------------------
// tlf_front
// Accepts input bytes, holds the line state and builds one descriptor per byte that is not squeezed.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_front #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      in_byte,
  input  wire logic                            file_start,
  input  wire logic                            cfg_write,
  input  wire logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tlf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output tlf_pkg::desc_t                       q_desc,
  output logic [4*NUMBER_DIGITS-1:0]           q_number
);

  localparam int NW = 4 * NUMBER_DIGITS;
  localparam logic [NW-1:0] NUMBER_ONE = NW'(1);

  tlf_pkg::cfg_t   cfg;
  logic            prev_nl;
  logic [1:0]      blank_run;
  logic [NW-1:0]   line_number;

  logic            fire;
  logic            pwn_base;
  logic [1:0]      br_base;
  logic [NW-1:0]   ln_base;
  logic [NW-1:0]   ln_bumped;
  logic            is_nl;
  logic            sq;
  logic [1:0]      br_inc;
  logic            drop;
  logic            nb, na, show_v, show_e, show_t, caret_mode;
  tlf_pkg::desc_t  desc;

  assign full  = q_full;
  assign fire  = push && !q_full;
  assign is_nl = (in_byte == tlf_pkg::CHAR_NL);

  // state as seen by this byte, after an optional file restart
  assign pwn_base = file_start ? 1'b1 : prev_nl;
  assign br_base  = file_start ? 2'd0 : blank_run;
  assign ln_base  = file_start ? NUMBER_ONE : line_number;

  assign sq     = cfg.squeeze_blank && is_nl && pwn_base;
  assign br_inc = (br_base == 2'd2) ? 2'd2 : br_base + 2'd1;
  assign drop   = sq && (br_inc == 2'd2);

  assign nb         = cfg.number_nonblank;
  assign na         = cfg.number_all && !nb;
  assign show_v     = cfg.show_nonprinting;
  assign show_e     = cfg.show_ends && !show_v;
  assign show_t     = cfg.show_tabs && !show_v;
  assign caret_mode = show_v || show_e || show_t;

  // decimal increment, holding at all nines
  always_comb begin
    logic       carry;
    logic [3:0] d;
    carry = 1'b0;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (ln_base[4*k +: 4] != tlf_pkg::BCD_NINE) carry = 1'b1;
    end
    ln_bumped = ln_base;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      d = ln_base[4*k +: 4];
      if (carry) begin
        if (d == tlf_pkg::BCD_NINE) begin
          ln_bumped[4*k +: 4] = tlf_pkg::BCD_ZERO;
        end else begin
          ln_bumped[4*k +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_comb begin
    desc.num_en    = (na || (nb && !is_nl)) && pwn_base;
    desc.lead_en   = 1'b0;
    desc.lead_byte = tlf_pkg::CHAR_CARET;
    desc.last_byte = in_byte;
    if (show_t && in_byte == tlf_pkg::CHAR_TAB) begin
      desc.lead_en   = 1'b1;
      desc.last_byte = tlf_pkg::CHAR_I;
    end else if (show_e && is_nl) begin
      desc.lead_en   = 1'b1;
      desc.lead_byte = tlf_pkg::CHAR_DOLLAR;
    end else if (caret_mode && in_byte < tlf_pkg::CTRL_LIMIT && !is_nl
                 && in_byte != tlf_pkg::CHAR_TAB) begin
      desc.lead_en   = 1'b1;
      desc.last_byte = in_byte + tlf_pkg::CARET_OFFSET;
    end else if (caret_mode && in_byte == tlf_pkg::CHAR_DEL) begin
      desc.lead_en   = 1'b1;
      desc.last_byte = in_byte - tlf_pkg::CARET_OFFSET;
    end
  end

  assign q_push   = fire && !drop;
  assign q_desc   = desc;
  assign q_number = ln_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg         <= '0;
      prev_nl     <= 1'b1;
      blank_run   <= 2'd0;
      line_number <= NUMBER_ONE;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tlf_pkg::REG_NUMBER_ALL:       cfg.number_all       <= cfg_data[0];
          tlf_pkg::REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= cfg_data[0];
          tlf_pkg::REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data[0];
          tlf_pkg::REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data[0];
          tlf_pkg::REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data[0];
          tlf_pkg::REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data[0];
          default: ;
        endcase
      end
      if (fire) begin
        blank_run <= sq ? br_inc : 2'd0;
        if (drop) begin
          // squeezed newline: only the restart and run count take effect
          prev_nl     <= pwn_base;
          line_number <= ln_base;
        end else begin
          prev_nl     <= (desc.last_byte == tlf_pkg::CHAR_NL);
          line_number <= desc.num_en ? ln_bumped : ln_base;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tlf_queue.sv =====
// ----------------------------------------------------------------------------
// tlf_queue
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_line_filter_macros.svh"

module tlf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tlf_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == COUNT_FULL);
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (pop && valid)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      case ({push && !full, pop && valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `TLF_ASSERT(a_count_range, clk, rst, count <= COUNT_FULL, "queue count out of range")
  `TLF_ASSERT_NEVER(a_push_full, clk, rst, push && full, "push into full queue")
  `TLF_ASSERT_NEVER(a_pop_empty, clk, rst, pop && !valid, "pop from empty queue")
  `TLF_ASSERT(a_count_up, clk, rst, (push && !pop && !full) |=> count == $past(count) + 1'b1,
              "queue count did not advance on push")

endmodule

`default_nettype wire

// ===== src/tlf_back.sv =====
// ----------------------------------------------------------------------------
// tlf_back
// Expands each descriptor into its output bytes, one per cycle while the output is empty or popped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_line_filter_macros.svh"

module tlf_back #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire tlf_pkg::desc_t                 q_desc,
  input  wire logic [4*NUMBER_DIGITS-1:0]     q_number,
  output logic                                q_pop,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          out_byte,
  output logic                                last_of_run
);

  localparam int PW = $clog2(NUMBER_DIGITS + 3);
  localparam logic [PW-1:0] POS_FIRST = '0;
  localparam logic [PW-1:0] POS_TAB   = PW'(NUMBER_DIGITS);
  localparam logic [PW-1:0] POS_LEAD  = PW'(NUMBER_DIGITS + 1);
  localparam logic [PW-1:0] POS_FINAL = PW'(NUMBER_DIGITS + 2);

  logic          started;
  logic [PW-1:0] pos;
  logic          out_valid;

  logic          can_load, emit;
  logic [PW-1:0] start_pos, cur_pos, next_pos;
  logic [7:0]    digit_chars [NUMBER_DIGITS];
  logic [7:0]    cur_byte;

  assign empty    = !out_valid;
  assign can_load = !out_valid || pop;
  assign emit     = q_valid && can_load;

  assign start_pos = q_desc.num_en  ? POS_FIRST :
                     q_desc.lead_en ? POS_LEAD  : POS_FINAL;
  assign cur_pos   = started ? pos : start_pos;
  assign next_pos  = (cur_pos == POS_TAB && !q_desc.lead_en) ? POS_FINAL : cur_pos + 1'b1;
  assign q_pop     = emit && (cur_pos == POS_FINAL);

  // right-justified digits: leading zeros above the units digit print as spaces
  always_comb begin
    logic       zero_run;
    logic [3:0] d;
    zero_run = 1'b1;
    for (int j = NUMBER_DIGITS - 1; j >= 0; j--) begin
      d        = q_number[4*j +: 4];
      zero_run = zero_run && (d == tlf_pkg::BCD_ZERO);
      digit_chars[NUMBER_DIGITS-1-j] = (zero_run && j != 0) ? tlf_pkg::CHAR_SPACE
                                                             : tlf_pkg::CHAR_ZERO + {4'd0, d};
    end
  end

  always_comb begin
    if (cur_pos == POS_FINAL) begin
      cur_byte = q_desc.last_byte;
    end else if (cur_pos == POS_LEAD) begin
      cur_byte = q_desc.lead_byte;
    end else if (cur_pos == POS_TAB) begin
      cur_byte = tlf_pkg::CHAR_TAB;
    end else begin
      cur_byte = tlf_pkg::CHAR_SPACE;
      for (int p = 0; p < NUMBER_DIGITS; p++) begin
        if (cur_pos == PW'(p)) cur_byte = digit_chars[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      pos       <= POS_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (can_load) out_valid <= emit;
      if (emit) begin
        started <= (cur_pos != POS_FINAL);
        pos     <= next_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= cur_byte;
      last_of_run <= (cur_pos == POS_FINAL);
    end
  end

  `TLF_ASSERT(a_started_has_entry, clk, rst, started |-> q_valid,
              "sequencer mid-request with no queued descriptor")
  `TLF_ASSERT(a_pos_range, clk, rst, started |-> pos <= POS_FINAL, "sequencer position out of range")
  `TLF_ASSERT(a_pop_marks_last, clk, rst, q_pop |=> last_of_run && !empty,
              "descriptor retired without its final byte")

endmodule

`default_nettype wire

// ===== src/text_line_filter.sv =====
// ----------------------------------------------------------------------------
// text_line_filter
// Byte-stream rewriter: line numbers, blank-line squeezing, caret notation.
//
//   channel  direction  handshake      payload
//   input    in         push / full    in_byte, file_start
//   result   out        pop / empty    out_byte, last_of_run
//   config   in         cfg_write      cfg_index, cfg_data
//
// An input byte is taken every cycle while the descriptor queue has room.
// A byte expands to 0 to NUMBER_DIGITS+3 output bytes; the back end sends
// one output byte per cycle while the output is empty or popped. The queue
// (QUEUE_DEPTH requests) lets input and output stall independently.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_filter #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      in_byte,
  input  wire logic                            file_start,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [7:0]                           out_byte,
  output logic                                 last_of_run,
  input  wire logic                            cfg_write,
  input  wire logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tlf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NW = 4 * NUMBER_DIGITS;
  localparam int DW = NW + $bits(tlf_pkg::desc_t);

  logic                q_full, q_push, q_valid, q_pop;
  tlf_pkg::desc_t      f_desc, b_desc;
  logic [NW-1:0]       f_number, b_number;
  logic [DW-1:0]       q_rdata;

  tlf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .file_start (file_start),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_desc     (f_desc),
    .q_number   (f_number)
  );

  tlf_queue #(.WIDTH(DW), .DEPTH(tlf_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_number, f_desc}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign b_number = q_rdata[DW-1 -: NW];
  assign b_desc   = q_rdata[$bits(tlf_pkg::desc_t)-1:0];

  tlf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_desc      (b_desc),
    .q_number    (b_number),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
